[rtl/i2cseq_pkg.sv]
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Shared types and codes for the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

   // buffer depth default
   localparam int MAX_LEN_DEF = 256;

   // stream payload widths
   localparam int REQ_BITS  = 38;
   localparam int REQ_TDATA = 40;
   localparam int REQ_TUSER = 2;
   localparam int RSP_BITS  = 36;
   localparam int RSP_TDATA = 40;

   // input word kinds
   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_STATUS = 2'd2
   } opcode_type;

   // bus operation kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_CONT  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // acknowledge variants
   localparam logic [1:0] ACK_NONE = 2'd0;
   localparam logic [1:0] ACK_ON   = 2'd1;
   localparam logic [1:0] ACK_HIGH = 2'd2;

   // completion codes
   localparam logic [1:0] DONE_OK    = 2'd0;
   localparam logic [1:0] DONE_ERROR = 2'd1;
   localparam logic [1:0] DONE_NAK   = 2'd2;

   // register indexes
   localparam logic CSR_ACK_ENABLE = 1'b0;
   localparam logic CSR_ACK_HIGH   = 1'b1;

   // input word fields, last field in the lowest bits
   typedef struct packed {
      logic       status_ready;
      logic       status_nak;
      logic       status_lost;
      logic       status_cmd_error;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       no_stop;
      logic       no_start;
      logic [7:0] read_length;
      logic [7:0] write_length;
   } req_type;

   // result word fields, last field in the lowest bits
   typedef struct packed {
      logic       spurious;
      logic [7:0] rd_byte;
      logic [7:0] rd_index;
      logic       rd_valid;
      logic [1:0] done_code;
      logic       done_res;
      logic [1:0] op_ack;
      logic       op_receive;
      logic [1:0] op_kind;
      logic       op_valid;
      logic [7:0] tx_byte;
      logic       tx_valid;
   } rsp_type;

endpackage

[rtl/i2cseq_ram.sv]
// ----------------------------------------------------------------------------
// i2cseq_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module i2cseq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/i2c_master_transfer_sequencer_top.sv]
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// Sequences one i2c master write-then-read transfer from begin, load and
// controller status words, one result word per input word.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req_*     in   req_tvalid/req_tready  tuser opcode, tdata item fields
//  rsp_*     out  rsp_tvalid/rsp_tready  tdata result fields
//  csr_*     in   csr_valid/csr_ready    csr_index, csr_data
//
//  one word per cycle sustained while rsp_tready is high, each word passes the input then the output register
//  the write buffer read is issued when a word is accepted and registered
//  in the ram, so the buffer entry is ready when the word is processed
//  reset clears the counters and flags; the buffer needs no clearing pass
//  a stalled result holds in the output register, the input stage keeps
//  taking words while the output register is free or being emptied
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top
   import i2cseq_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // write_length, read_length, no_start, no_stop, byte_index, data_byte,
   // status_cmd_error, status_lost, status_nak, status_ready, zero fill
   input  logic [REQ_TDATA-1:0] req_tdata,
   // opcode
   input  logic [REQ_TUSER-1:0] req_tuser,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // tx_valid, tx_byte, op_valid, op_kind, op_receive, op_ack, done_res,
   // done_code, rd_valid, rd_index, rd_byte, spurious, zero fill
   output logic [RSP_TDATA-1:0] rsp_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic                 csr_data
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);

   // input stage
   logic           in_valid_ff, in_valid_in;
   req_type        req_ff;
   logic [1:0]     op_ff;
   req_type        req_word;

   // output stage
   logic           out_valid_ff, out_valid_in;
   rsp_type        rsp_ff, rsp_in;

   // transfer state
   logic [LW-1:0]  wl_ff, wl_in;
   logic [LW-1:0]  rl_ff, rl_in;
   logic [LW-1:0]  wc_ff, wc_in;
   logic signed [LW:0] rc_ff, rc_in;
   logic           sw_ff, sw_in;

   // configuration
   logic           ack_en_ff, ack_hi_ff;

   // handshake and buffer
   logic           accept, fire;
   logic           ram_we, ram_re;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [7:0]     ram_rdata;

   // begin helpers
   logic [LW-1:0]  beg_wl, beg_rl;
   logic           beg_sw;
   logic [1:0]     ack_code;
   logic signed [LW+1:0] rd_rem;
   logic           rd_open;

   assign req_word = req_type'(req_tdata[REQ_BITS-1:0]);

   // handshake, nothing is taken while in reset
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !reset && (!in_valid_ff || fire);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   // buffer write on load, prefetch read for every other word
   assign ram_we    = accept && (req_tuser == OP_LOAD)
                      && (32'(req_word.byte_index) < MAX_LEN);
   assign ram_waddr = AW'(req_word.byte_index);
   assign ram_re    = accept && (req_tuser != OP_LOAD);
   assign ram_raddr = (req_tuser == OP_BEGIN) ? '0
                      : ((32'(wc_in) < MAX_LEN) ? AW'(wc_in) : '0);

   i2cseq_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LEN)
   ) u_wbuf (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_word.data_byte),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // begin word decode, lengths saturate at the buffer depth
   assign beg_wl = (32'(req_ff.write_length) > MAX_LEN) ? LW'(MAX_LEN)
                   : LW'(req_ff.write_length);
   assign beg_rl = (32'(req_ff.read_length) > MAX_LEN) ? LW'(MAX_LEN)
                   : LW'(req_ff.read_length);
   assign beg_sw = !req_ff.no_stop;

   assign ack_code = ack_en_ff ? (ack_hi_ff ? ACK_HIGH : ACK_ON) : ACK_NONE;

   // read phase position
   assign rd_open = (rl_ff != '0) && ($signed({1'b0, rl_ff}) > rc_ff);
   assign rd_rem  = $signed({2'b00, rl_ff}) - $signed({rc_ff[LW], rc_ff});

   // sequencing of one word
   always_comb begin
      rsp_in = '0;
      wl_in  = wl_ff;
      rl_in  = rl_ff;
      wc_in  = wc_ff;
      rc_in  = rc_ff;
      sw_in  = sw_ff;
      if (fire) begin
         case (op_ff)
            OP_BEGIN: begin
               wl_in = beg_wl;
               rl_in = beg_rl;
               sw_in = beg_sw;
               wc_in = '0;
               rc_in = '1;
               rsp_in.op_valid = 1'b1;
               rsp_in.op_ack   = ack_code;
               if (!req_ff.no_start) begin
                  rsp_in.op_kind    = KIND_START;
                  rsp_in.op_receive = (beg_wl == '0);
               end else if (beg_wl != '0) begin
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = ram_rdata;
                  rsp_in.op_kind  = (beg_sw && beg_wl == LW'(1) && beg_rl == '0)
                                    ? KIND_END : KIND_CONT;
                  wc_in = LW'(1);
               end else begin
                  rsp_in.op_kind    = (beg_sw && beg_rl == LW'(1)) ? KIND_END : KIND_CONT;
                  rsp_in.op_receive = 1'b1;
                  rc_in = '0;
               end
            end
            OP_STATUS: begin
               if (!(req_ff.status_cmd_error || req_ff.status_lost
                     || req_ff.status_ready)) begin
                  rsp_in.spurious = 1'b1;
               end else if (req_ff.status_cmd_error || req_ff.status_lost) begin
                  rsp_in.done_res  = 1'b1;
                  rsp_in.done_code = DONE_ERROR;
               end else if (req_ff.status_nak) begin
                  rsp_in.done_res  = 1'b1;
                  rsp_in.done_code = DONE_NAK;
               end else if (wl_ff != '0 && wc_ff < wl_ff) begin
                  // next write byte
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = ram_rdata;
                  rsp_in.op_valid = 1'b1;
                  rsp_in.op_ack   = ack_code;
                  rsp_in.op_kind  = KIND_CONT;
                  if (wc_ff + LW'(1) == wl_ff) begin
                     if (sw_ff && rl_ff == '0) begin
                        rsp_in.op_kind = KIND_END;
                     end else begin
                        rc_in = '1;
                     end
                  end
                  wc_in = wc_ff + LW'(1);
               end else if (rd_open) begin
                  // store any received byte, request the next one if more remain
                  if (!rc_ff[LW]) begin
                     rsp_in.rd_valid = 1'b1;
                     rsp_in.rd_index = 8'(rc_ff);
                     rsp_in.rd_byte  = req_ff.data_byte;
                  end
                  rc_in = rc_ff + (LW+1)'(1);
                  if (rd_rem <= (LW+2)'(1)) begin
                     rsp_in.done_res  = 1'b1;
                     rsp_in.done_code = DONE_OK;
                  end else begin
                     rsp_in.op_valid   = 1'b1;
                     rsp_in.op_ack     = ack_code;
                     rsp_in.op_receive = 1'b1;
                     rsp_in.op_kind    = (sw_ff && rd_rem == (LW+2)'(2))
                                         ? KIND_END : KIND_CONT;
                  end
               end else begin
                  rsp_in.done_res  = 1'b1;
                  rsp_in.done_code = DONE_OK;
               end
            end
            default: begin
               // load words and the unused opcode give an all-zero result
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wl_ff        <= '0;
         rl_ff        <= '0;
         wc_ff        <= '0;
         rc_ff        <= '1;
         sw_ff        <= 1'b0;
         ack_en_ff    <= 1'b0;
         ack_hi_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         wl_ff        <= wl_in;
         rl_ff        <= rl_in;
         wc_ff        <= wc_in;
         rc_ff        <= rc_in;
         sw_ff        <= sw_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACK_ENABLE: ack_en_ff <= csr_data;
               CSR_ACK_HIGH:   ack_hi_ff <= csr_data;
               default:        ack_en_ff <= ack_en_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
         op_ff  <= req_tuser;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA - RSP_BITS)'(0), rsp_ff};

`ifndef SYNTH
   // write position never passes the write length
   a_wc_bound: assert property (@(posedge clock) disable iff (reset)
      wc_ff <= wl_ff)
      else $error("write count beyond write length");

   // read position stays within minus one and the read length
   a_rc_bound: assert property (@(posedge clock) disable iff (reset)
      rc_ff[LW] ? (&rc_ff) : (rc_ff[LW-1:0] <= rl_ff))
      else $error("read count out of range");

   // a processed word always lands in the output register
   a_fire_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed word lost");

   // a placed byte always comes with an issued operation
   a_tx_op: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ff.tx_valid |-> rsp_ff.op_valid)
      else $error("byte placed without bus operation");

   // completion or a spurious event issues no operation and no byte
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (rsp_ff.done_res || rsp_ff.spurious)
      |-> !rsp_ff.op_valid && !rsp_ff.tx_valid)
      else $error("operation issued with completion or spurious event");
`endif

endmodule
